// ===== rtl/casp_pkg.sv =====
// ----------------------------------------------------------------------------
// casp_pkg: shared types for the circular array segment permuter
// Command kinds and the decoded command that moves from front to back.
// ----------------------------------------------------------------------------
`default_nettype none

package casp_pkg;

	typedef enum logic [2:0] {
		KIND_CLEAR   = 3'd0,
		KIND_LOAD    = 3'd1,
		KIND_REVERSE = 3'd2,
		KIND_ROTATE  = 3'd3,
		KIND_SWAP    = 3'd4,
		KIND_DUMP    = 3'd5
	} kind_t;

	// Command as queued between the front and the back
	typedef struct packed {
		kind_t              kind;
		logic signed [31:0] value;
		logic signed [31:0] start_req;
		logic [30:0]        length;
		logic signed [31:0] amount;
	} cmd_t;

endpackage

`default_nettype wire

// ===== rtl/casp_front.sv =====
// ----------------------------------------------------------------------------
// casp_front: command intake
// Accepts input transfers, drops commands that cannot change anything and
// holds the rest in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module casp_front (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	input  casp_pkg::cmd_t    in_cmd,
	output logic              cmd_valid,
	input  wire               cmd_ready,
	output casp_pkg::cmd_t    cmd
);
	import casp_pkg::*;

	cmd_t       ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       keep;
	logic       push;
	logic       pop;

	// Classify: unused kinds and zero-length segment operations are dropped
	always_comb begin
		unique case (in_cmd.kind)
			KIND_CLEAR, KIND_LOAD, KIND_DUMP: keep = 1'b1;
			KIND_REVERSE, KIND_ROTATE, KIND_SWAP: keep = (in_cmd.length != 31'd0);
			default: keep = 1'b0;
		endcase
	end

	assign in_ready  = (cnt_q != 2'd2);
	assign push      = in_valid && in_ready && keep;
	assign cmd_valid = (cnt_q != 2'd0);
	assign pop       = cmd_valid && cmd_ready;
	assign cmd       = ent_q[rd_ptr_q];

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= in_cmd;
		end
	end

	// Queue pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/casp_mod.sv =====
// ----------------------------------------------------------------------------
// casp_mod: serial modulo unit
// Reduces a signed 33-bit value modulo a small positive divisor, one
// dividend bit per cycle; the result is always in 0..divisor-1.
// ----------------------------------------------------------------------------
`default_nettype none

module casp_mod #(
	parameter int CW = 7
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	input  wire signed [32:0]  dividend,
	input  wire [CW-1:0]       divisor,
	output logic               done,
	output logic [CW-1:0]      result
);
	localparam int NBITS = 33;

	logic [32:0]   mag_q;
	logic [CW-1:0] rem_q;
	logic [CW-1:0] div_q;
	logic          neg_q;
	logic          busy_q;
	logic [5:0]    cnt_q;
	logic [CW:0]   trial;
	logic [CW:0]   rem_next;

	// One restoring step
	assign trial    = {rem_q, mag_q[32]};
	assign rem_next = (trial >= {1'b0, div_q}) ? (trial - {1'b0, div_q}) : trial;

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= dividend[32] ? (33'd0 - 33'(dividend)) : 33'(dividend);
			rem_q <= '0;
			div_q <= divisor;
			neg_q <= dividend[32];
		end else if (busy_q) begin
			mag_q <= {mag_q[31:0], 1'b0};
			rem_q <= rem_next[CW-1:0];
		end
		// Fold a negative dividend back into range
		if (busy_q && cnt_q == 6'(NBITS - 1)) begin
			if (neg_q && rem_next != '0) begin
				result <= CW'({1'b0, div_q} - rem_next);
			end else begin
				result <= rem_next[CW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(NBITS - 1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/casp_back.sv =====
// ----------------------------------------------------------------------------
// casp_back: command execution
// Holds the array in a two-bank memory. Segment operations copy the live
// bank into the other one through the permutation, then swap banks.
// ----------------------------------------------------------------------------
`default_nettype none

module casp_back #(
	parameter int MAX_LEN = 64
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               cmd_valid,
	output logic              cmd_ready,
	input  casp_pkg::cmd_t    cmd,
	output logic              out_valid,
	input  wire               out_ready,
	output logic [31:0]       out_element,
	output logic              out_last
);
	import casp_pkg::*;

	localparam int CW = $clog2(MAX_LEN + 2);
	localparam int IW = $clog2(MAX_LEN);
	localparam int AW = IW + 1;
	localparam logic [CW-1:0] MAXC   = CW'(MAX_LEN);
	localparam logic [CW-1:0] LCLAMP = CW'(MAX_LEN + 1);

	localparam logic [1:0] MS_BASE = 2'd0;
	localparam logic [1:0] MS_FULL = 2'd1;
	localparam logic [1:0] MS_REM  = 2'd2;
	localparam logic [1:0] MS_LAST = 2'd3;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_MOD   = 6'b000010,
		S_PERM  = 6'b000100,
		S_DRAIN = 6'b001000,
		S_DRD   = 6'b010000,
		S_DLD   = 6'b100000
	} state_t;

	state_t             state_q;
	kind_t              kind_q;
	logic signed [31:0] amount_q;
	logic [CW-1:0]      lc_q;
	logic [CW-1:0]      n_q;
	logic               bank_q;
	logic [IW-1:0]      base_q;
	logic [CW-1:0]      sfull_q;
	logic [CW-1:0]      slast_q;
	logic [1:0]         mstep_q;
	logic [CW-1:0]      r_q;
	logic [IW-1:0]      p_q;
	logic [CW-1:0]      fs_q;
	logic [CW-1:0]      c_q;
	logic [CW-1:0]      t_q;
	logic [IW-1:0]      p_s1;
	logic               v_s1;
	logic [IW-1:0]      k_q;
	logic [31:0]        rd_q;
	logic [31:0]        mem_q [2**AW];

	logic               mod_go_q;
	logic signed [32:0] mod_dividend_q;
	logic [CW-1:0]      mod_divisor_q;
	logic               mod_done;
	logic [CW-1:0]      mod_result;

	logic [CW-1:0]      lc_in;
	logic [CW-1:0]      m1;
	logic signed [32:0] neg_amount;
	logic               is_rot;
	logic               is_swap;
	logic [CW-1:0]      left;
	logic [CW:0]        fw;
	logic               whole;
	logic [CW-1:0]      fl;
	logic [CW-1:0]      adv;
	logic               boundary;
	logic [CW:0]        f;
	logic [CW:0]        q_sum;
	logic [IW-1:0]      q;
	logic [CW-1:0]      new_left;
	logic               next_short;
	logic               load_we;
	logic               we;
	logic [AW-1:0]      waddr;
	logic [31:0]        wdata;
	logic [AW-1:0]      raddr;

	casp_mod #(.CW(CW)) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_go_q),
		.dividend (mod_dividend_q),
		.divisor  (mod_divisor_q),
		.done     (mod_done),
		.result   (mod_result)
	);

	assign cmd_ready  = (state_q == S_IDLE);
	assign lc_in      = (cmd.length > 31'(MAX_LEN)) ? LCLAMP : CW'(cmd.length);
	assign m1         = (lc_q < n_q) ? lc_q : n_q;
	assign neg_amount = 33'sd0 - 33'(amount_q);
	assign is_rot     = (kind_q == KIND_ROTATE);
	assign is_swap    = (kind_q == KIND_SWAP);

	// Fragment geometry at the current position
	always_comb begin
		left     = n_q - fs_q;
		fw       = is_swap ? {lc_q, 1'b0} : {1'b0, lc_q};
		whole    = (fw <= {1'b0, left});
		fl       = (is_rot && !whole) ? left : fw[CW-1:0];
		adv      = fl;
		boundary = is_rot ? (c_q + CW'(1) == fl) : (whole && (c_q + CW'(1) == fw[CW-1:0]));
		new_left = left - adv;
		next_short = ({1'b0, lc_q} > {1'b0, new_left});
		case (kind_q)
			KIND_ROTATE: f = {1'b0, fs_q} + {1'b0, t_q};
			KIND_REVERSE: begin
				if (whole) begin
					f = {1'b0, fs_q} + {1'b0, lc_q} - (CW+1)'(1) - {1'b0, c_q};
				end else begin
					f = {1'b0, r_q};
				end
			end
			KIND_SWAP: begin
				if (!whole) begin
					f = {1'b0, r_q};
				end else if (c_q < lc_q) begin
					f = {1'b0, fs_q} + {1'b0, c_q} + {1'b0, lc_q};
				end else begin
					f = {1'b0, fs_q} + {1'b0, c_q} - {1'b0, lc_q};
				end
			end
			default: f = {1'b0, r_q};
		endcase
		q_sum = (CW+1)'(base_q) + f;
		if (q_sum >= {1'b0, n_q}) begin
			q = IW'(q_sum - {1'b0, n_q});
		end else begin
			q = IW'(q_sum);
		end
	end

	// Memory port selection
	assign load_we = (state_q == S_IDLE) && cmd_valid && (cmd.kind == KIND_LOAD) && (n_q < MAXC);
	assign we      = v_s1 || load_we;
	assign waddr   = v_s1 ? {~bank_q, p_s1} : {bank_q, n_q[IW-1:0]};
	assign wdata   = v_s1 ? rd_q : 32'(cmd.value);
	assign raddr   = (state_q == S_PERM) ? {bank_q, q} : {bank_q, k_q};

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rd_q <= mem_q[raddr];
	end

	// Payload registers
	always_ff @(posedge clk) begin
		p_s1 <= p_q;
		if (state_q == S_IDLE && cmd_valid) begin
			kind_q         <= cmd.kind;
			amount_q       <= cmd.amount;
			lc_q           <= lc_in;
			mod_dividend_q <= 33'(cmd.start_req);
			mod_divisor_q  <= n_q;
		end
		if (state_q == S_MOD && mod_done) begin
			unique case (mstep_q)
				MS_BASE: begin
					base_q         <= mod_result[IW-1:0];
					mod_dividend_q <= neg_amount;
					mod_divisor_q  <= m1;
				end
				MS_FULL: begin
					sfull_q        <= mod_result;
					mod_dividend_q <= 33'(n_q);
					mod_divisor_q  <= lc_q;
				end
				MS_REM: begin
					mod_dividend_q <= neg_amount;
					mod_divisor_q  <= mod_result;
				end
				MS_LAST: slast_q <= mod_result;
				default: slast_q <= slast_q;
			endcase
		end
		if (state_q == S_DLD) begin
			out_element <= rd_q;
			out_last    <= (k_q == IW'(n_q - CW'(1)));
		end
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			n_q       <= '0;
			bank_q    <= 1'b0;
			mstep_q   <= MS_BASE;
			mod_go_q  <= 1'b0;
			v_s1      <= 1'b0;
			r_q       <= '0;
			p_q       <= '0;
			fs_q      <= '0;
			c_q       <= '0;
			t_q       <= '0;
			k_q       <= '0;
			out_valid <= 1'b0;
		end else begin
			mod_go_q <= 1'b0;
			v_s1     <= 1'b0;
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						unique case (cmd.kind)
							KIND_CLEAR: n_q <= '0;
							KIND_LOAD: begin
								if (n_q < MAXC) begin
									n_q <= n_q + CW'(1);
								end
							end
							KIND_DUMP: begin
								if (n_q != '0) begin
									k_q     <= '0;
									state_q <= S_DRD;
								end
							end
							default: begin
								if (n_q != '0) begin
									mstep_q  <= MS_BASE;
									mod_go_q <= 1'b1;
									state_q  <= S_MOD;
								end
							end
						endcase
					end
				end
				S_MOD: begin
					if (mod_done) begin
						// Chain the next reduction or start the copy pass
						if (mstep_q == MS_BASE && is_rot) begin
							mstep_q  <= MS_FULL;
							mod_go_q <= 1'b1;
						end else if (mstep_q == MS_FULL && lc_q < n_q) begin
							mstep_q  <= MS_REM;
							mod_go_q <= 1'b1;
						end else if (mstep_q == MS_REM && mod_result != '0) begin
							mstep_q  <= MS_LAST;
							mod_go_q <= 1'b1;
						end else begin
							state_q <= S_PERM;
							r_q     <= '0;
							fs_q    <= '0;
							c_q     <= '0;
							p_q     <= (mstep_q == MS_BASE) ? mod_result[IW-1:0] : base_q;
							t_q     <= (mstep_q == MS_FULL) ? mod_result : sfull_q;
						end
					end
				end
				S_PERM: begin
					// Read the source of position p, write it in the following cycle
					v_s1 <= 1'b1;
					r_q  <= r_q + CW'(1);
					p_q  <= (CW'(p_q) + CW'(1) == n_q) ? '0 : p_q + IW'(1);
					if (boundary) begin
						fs_q <= fs_q + adv;
						c_q  <= '0;
						t_q  <= next_short ? slast_q : sfull_q;
					end else begin
						c_q <= c_q + CW'(1);
						t_q <= (t_q + CW'(1) == fl) ? '0 : t_q + CW'(1);
					end
					if (r_q + CW'(1) == n_q) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					bank_q  <= ~bank_q;
					state_q <= S_IDLE;
				end
				S_DRD: begin
					if (!out_valid) begin
						state_q <= S_DLD;
					end
				end
				S_DLD: begin
					out_valid <= 1'b1;
					if (k_q == IW'(n_q - CW'(1))) begin
						state_q <= S_IDLE;
					end else begin
						k_q     <= k_q + IW'(1);
						state_q <= S_DRD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/circular_array_segment_permuter_unit.sv =====
// ----------------------------------------------------------------------------
// circular_array_segment_permuter_unit: segmented reverse/rotate/swap array
// Loads signed words into a circular array and permutes fixed-length
// fragments of it; dump streams the array back out.
// ----------------------------------------------------------------------------
// Clear and load complete in the back end's idle state. Reverse, rotate
// and swap first reduce start_req modulo the element count in a bit-serial
// modulo unit (rotate adds up to three more reductions for the shift
// amounts), then copy all n elements through the permutation into the
// other memory bank at one element per cycle through the single memory
// read and write port. Dump presents one element at a time and waits until
// the previous one has been taken before it presents the next. A two-entry
// command queue sits in front, so new transfers are accepted while the
// back end is busy, until the queue is full.
`default_nettype none

module circular_array_segment_permuter_unit #(
	parameter int MAX_LEN = 64
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_tvalid,
	output logic         s_tready,
	// value[31:0], start_req[63:32], length[94:64], amount[126:95], zero[127]
	input  wire  [127:0] s_tdata,
	// kind[2:0]
	input  wire  [2:0]   s_tuser,
	output logic         m_tvalid,
	input  wire          m_tready,
	// element[31:0]
	output logic [31:0]  m_tdata,
	output logic         m_tlast
);
	import casp_pkg::*;

	cmd_t in_cmd;
	cmd_t cmd;
	logic cmd_valid;
	logic cmd_ready;

	// Unpack the input transfer
	always_comb begin
		in_cmd.kind      = kind_t'(s_tuser);
		in_cmd.value     = s_tdata[31:0];
		in_cmd.start_req = s_tdata[63:32];
		in_cmd.length    = s_tdata[94:64];
		in_cmd.amount    = s_tdata[126:95];
	end

	casp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_cmd    (in_cmd),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	casp_back #(.MAX_LEN(MAX_LEN)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_ready   (cmd_ready),
		.cmd         (cmd),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_element (m_tdata),
		.out_last    (m_tlast)
	);

endmodule

`default_nettype wire
